@@ rtl/carp_pkg.sv @@
// shared types, codes and helper function of the chord arpeggiator
package carp_pkg;

   localparam int NOTE_FIELDS = 8;
   localparam int NOTE_W      = 7;
   localparam int COUNT_W     = 4;
   localparam int POS_W       = 3;
   localparam int RAND_W      = 32;
   localparam int DIV_BITS    = 8;
   localparam int DIV_STEPS   = RAND_W / DIV_BITS;
   localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

   localparam logic [RAND_W-1:0] DEFAULT_SEED = 32'h9e37_79b9;
   localparam logic [NOTE_W-1:0] RESET_NOTE   = 7'd60;

   localparam logic [1:0] ACT_STEP    = 2'd0;
   localparam logic [1:0] ACT_CHORD   = 2'd1;
   localparam logic [1:0] ACT_RESTART = 2'd2;

   localparam logic [2:0] PAT_UP     = 3'd0;
   localparam logic [2:0] PAT_DOWN   = 3'd1;
   localparam logic [2:0] PAT_UPDOWN = 3'd2;
   localparam logic [2:0] PAT_RANDOM = 3'd3;
   localparam logic [2:0] PAT_STRUM  = 3'd4;

   localparam logic CSR_PATTERN = 1'b0;
   localparam logic CSR_SEED    = 1'b1;

   typedef logic [NOTE_W-1:0] note_type;

   typedef struct packed {
      logic capture;
      logic restart;
      logic clear_strum;
      logic rand_start;
      logic div_step;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic [1:0] action;
      logic       rand_sel;
      logic       out_busy;
   } status_type;

   function automatic logic [RAND_W-1:0] xorshift_next(input logic [RAND_W-1:0] x_in);
      logic [RAND_W-1:0] x;
      x = x_in;
      x = x ^ (x << 13);
      x = x ^ (x >> 17);
      x = x ^ (x << 5);
      return x;
   endfunction

endpackage

@@ rtl/carp_ctrl.sv @@
// controller state machine of the chord arpeggiator
module carp_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  carp_pkg::status_type status,
   output carp_pkg::cmd_type    cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DECODE,
      ST_DIV,
      ST_EMIT
   } state_type;

   state_type                        state_ff, state_in;
   logic [carp_pkg::DIV_CNT_W-1:0]   count_ff, count_in;

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      count_in  = count_ff;
      req_ready = (state_ff == ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DECODE;
            end
         end
         ST_DECODE: begin
            unique case (status.action)
               carp_pkg::ACT_STEP: begin
                  if (status.rand_sel) begin
                     cmd.rand_start = 1'b1;
                     count_in       = '0;
                     state_in       = ST_DIV;
                  end else begin
                     state_in = ST_EMIT;
                  end
               end
               carp_pkg::ACT_CHORD: begin
                  cmd.clear_strum = 1'b1;
                  state_in        = ST_IDLE;
               end
               carp_pkg::ACT_RESTART: begin
                  cmd.restart = 1'b1;
                  state_in    = ST_IDLE;
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            count_in     = count_ff + 1'b1;
            if (count_ff == carp_pkg::DIV_CNT_W'(carp_pkg::DIV_STEPS - 1)) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!status.out_busy) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

`ifndef SYNTHESIS
   a_div_follows_seed_draw: assert property (@(posedge clock) disable iff (reset)
      cmd.rand_start |=> cmd.div_step)
      else $error("division did not start after generator draw");
   a_capture_on_transfer: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |-> (req_valid && req_ready))
      else $error("capture without request transfer");
   a_idle_after_emit: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> req_ready)
      else $error("controller not idle after emit");
`endif

endmodule

@@ rtl/carp_datapath.sv @@
// datapath of the chord arpeggiator: item capture, motion state, remainder unit, output register
module carp_datapath #(
   parameter int MAX_NOTES = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  carp_pkg::cmd_type    cmd,
   output carp_pkg::status_type status,
   input  logic [1:0]           req_action,
   input  logic [3:0]           req_note_count,
   input  carp_pkg::note_type   req_notes [carp_pkg::NOTE_FIELDS],
   input  logic                 csr_write,
   input  logic                 csr_index,
   input  logic [31:0]          csr_wdata,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output carp_pkg::note_type   rsp_played_note
);

   localparam int LIMIT = (MAX_NOTES < carp_pkg::NOTE_FIELDS) ?
                          MAX_NOTES : carp_pkg::NOTE_FIELDS;
   localparam logic [carp_pkg::COUNT_W-1:0] LIMIT_C = carp_pkg::COUNT_W'(LIMIT);

   // captured item
   logic [1:0]                       action_ff;
   logic [carp_pkg::COUNT_W-1:0]     count_ff;
   carp_pkg::note_type               notes_ff [carp_pkg::NOTE_FIELDS];

   // block state
   logic [2:0]                       pattern_ff;
   logic [carp_pkg::RAND_W-1:0]      seed_ff;
   logic [carp_pkg::RAND_W-1:0]      rand_state_ff;
   logic [carp_pkg::POS_W-1:0]       position_ff;
   logic                             direction_down_ff;
   logic [carp_pkg::COUNT_W-1:0]     strum_ff;
   carp_pkg::note_type               previous_note_ff;

   // remainder unit
   logic [carp_pkg::RAND_W-1:0]      dividend_ff;
   logic [carp_pkg::POS_W-1:0]       rem_ff, rem_in;

   logic                             rsp_valid_ff;
   carp_pkg::note_type               rsp_note_ff;

   logic [carp_pkg::RAND_W-1:0]      rand_next;
   logic [2:0]                       pattern_sat;
   logic                             empty;

   logic [carp_pkg::COUNT_W-1:0]     base;
   logic [carp_pkg::COUNT_W-1:0]     idx;
   logic [carp_pkg::COUNT_W-1:0]     position_in;
   logic                             direction_down_in;
   logic [carp_pkg::COUNT_W-1:0]     strum_in;
   carp_pkg::note_type               note_sel;
   logic [carp_pkg::COUNT_W-1:0]     trial;

   assign empty     = (count_ff == '0);
   assign rand_next = carp_pkg::xorshift_next(rand_state_ff);
   assign pattern_sat = (csr_wdata[2:0] > carp_pkg::PAT_STRUM) ?
                        carp_pkg::PAT_STRUM : csr_wdata[2:0];

   assign status.action   = action_ff;
   assign status.rand_sel = (pattern_ff == carp_pkg::PAT_RANDOM) && !empty;
   assign status.out_busy = rsp_valid_ff && !rsp_ready;

   // eight restoring steps per cycle, divisor at most eight
   always_comb begin
      rem_in = rem_ff;
      trial  = '0;
      for (int i = 0; i < carp_pkg::DIV_BITS; i++) begin
         trial = {rem_in, dividend_ff[carp_pkg::RAND_W-1-i]};
         if (trial >= count_ff) begin
            trial = trial - count_ff;
         end
         rem_in = trial[carp_pkg::POS_W-1:0];
      end
   end

   // note selection and next motion state
   always_comb begin
      base              = {1'b0, position_ff};
      idx               = '0;
      position_in       = {1'b0, position_ff};
      direction_down_in = direction_down_ff;
      strum_in          = strum_ff;
      case (pattern_ff)
         carp_pkg::PAT_DOWN: begin
            base        = (base >= count_ff) ? '0 : base;
            idx         = count_ff - 1'b1 - base;
            position_in = (base + 1'b1 == count_ff) ? '0 : base + 1'b1;
         end
         carp_pkg::PAT_UPDOWN: begin
            base        = (base >= count_ff) ? count_ff - 1'b1 : base;
            idx         = base;
            position_in = base;
            if (count_ff > 4'd1) begin
               if (direction_down_ff) begin
                  if (base <= 4'd1) begin
                     position_in       = '0;
                     direction_down_in = 1'b0;
                  end else begin
                     position_in = base - 1'b1;
                  end
               end else if (base + 1'b1 >= count_ff - 1'b1) begin
                  position_in       = count_ff - 1'b1;
                  direction_down_in = 1'b1;
               end else begin
                  position_in = base + 1'b1;
               end
            end
         end
         carp_pkg::PAT_RANDOM: begin
            idx         = {1'b0, rem_ff};
            position_in = {1'b0, rem_ff};
         end
         carp_pkg::PAT_STRUM: begin
            if (strum_ff < count_ff) begin
               idx      = strum_ff;
               strum_in = strum_ff + 1'b1;
            end else begin
               idx = '0;
            end
         end
         default: begin
            base        = (base >= count_ff) ? '0 : base;
            idx         = base;
            position_in = (base + 1'b1 == count_ff) ? '0 : base + 1'b1;
         end
      endcase
      note_sel = notes_ff[idx[carp_pkg::POS_W-1:0]];
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff        <= carp_pkg::PAT_UP;
         seed_ff           <= carp_pkg::DEFAULT_SEED;
         rand_state_ff     <= carp_pkg::DEFAULT_SEED;
         position_ff       <= '0;
         direction_down_ff <= 1'b0;
         strum_ff          <= '0;
         previous_note_ff  <= carp_pkg::RESET_NOTE;
         rsp_valid_ff      <= 1'b0;
      end else begin
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_write && csr_index == carp_pkg::CSR_SEED) begin
            seed_ff <= csr_wdata;
         end
         if (csr_write && csr_index == carp_pkg::CSR_PATTERN && pattern_sat != pattern_ff) begin
            pattern_ff        <= pattern_sat;
            position_ff       <= '0;
            direction_down_ff <= 1'b0;
            strum_ff          <= '0;
         end else if (cmd.restart) begin
            rand_state_ff     <= (seed_ff == '0) ? carp_pkg::DEFAULT_SEED : seed_ff;
            position_ff       <= '0;
            direction_down_ff <= 1'b0;
            strum_ff          <= '0;
            previous_note_ff  <= carp_pkg::RESET_NOTE;
         end else if (cmd.clear_strum) begin
            strum_ff <= '0;
         end else if (cmd.rand_start) begin
            rand_state_ff <= rand_next;
         end else if (cmd.emit && !empty) begin
            position_ff       <= position_in[carp_pkg::POS_W-1:0];
            direction_down_ff <= direction_down_in;
            strum_ff          <= strum_in;
            previous_note_ff  <= note_sel;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         action_ff <= req_action;
         count_ff  <= (req_note_count > LIMIT_C) ? LIMIT_C : req_note_count;
         for (int i = 0; i < carp_pkg::NOTE_FIELDS; i++) begin
            notes_ff[i] <= req_notes[i];
         end
      end
      if (cmd.rand_start) begin
         dividend_ff <= rand_next;
         rem_ff      <= '0;
      end else if (cmd.div_step) begin
         dividend_ff <= dividend_ff << carp_pkg::DIV_BITS;
         rem_ff      <= rem_in;
      end
      if (cmd.emit) begin
         rsp_note_ff <= empty ? previous_note_ff : note_sel;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_played_note = rsp_note_ff;

`ifndef SYNTHESIS
   a_rem_below_count: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && status.rand_sel) |-> (rem_ff < count_ff))
      else $error("random remainder not below note count");
   a_position_bound: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, position_ff} < LIMIT_C))
      else $error("position beyond chord limit");
   a_rand_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rand_state_ff != '0))
      else $error("generator state reached zero");
   a_emit_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> !(rsp_valid_ff && !rsp_ready))
      else $error("result overwritten before transfer");
`endif

endmodule

@@ rtl/chord_arpeggiator.sv @@
// Chord arpeggiator top level. One item is taken at a time: a request transfer
// is accepted only when the controller is idle. A chord change, restart or
// unused action passes accept and decode. A step in the up, down, up-down or
// strum pattern, or any step with an empty chord, passes accept, decode and
// emit; a random step also passes the division state, where the remainder
// unit works through the 32-bit generator value eight bits per cycle. A finished
// result waits in the output register while the next request is accepted; emit
// stalls only if a previous result is still not transferred. A pattern write
// that changes the pattern resets the motion state; a seed is used only on restart.
module chord_arpeggiator #(
   parameter int MAX_NOTES = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_action,
   input  logic [3:0]  req_note_count,
   input  logic [6:0]  req_note_a,
   input  logic [6:0]  req_note_b,
   input  logic [6:0]  req_note_c,
   input  logic [6:0]  req_note_d,
   input  logic [6:0]  req_note_e,
   input  logic [6:0]  req_note_f,
   input  logic [6:0]  req_note_g,
   input  logic [6:0]  req_note_h,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [6:0]  rsp_played_note,
   input  logic        csr_write,
   input  logic        csr_index,
   input  logic [31:0] csr_wdata
);

   carp_pkg::cmd_type    cmd;
   carp_pkg::status_type status;
   carp_pkg::note_type   req_notes [carp_pkg::NOTE_FIELDS];

   assign req_notes[0] = req_note_a;
   assign req_notes[1] = req_note_b;
   assign req_notes[2] = req_note_c;
   assign req_notes[3] = req_note_d;
   assign req_notes[4] = req_note_e;
   assign req_notes[5] = req_note_f;
   assign req_notes[6] = req_note_g;
   assign req_notes[7] = req_note_h;

   carp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   carp_datapath #(
      .MAX_NOTES (MAX_NOTES)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_action      (req_action),
      .req_note_count  (req_note_count),
      .req_notes       (req_notes),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_played_note (rsp_played_note)
   );

endmodule
